/* rtl/core/bls_pkg.sv */
// Package for the battery level smoother: widths, reset values, codes and state type.
package bls_pkg;

	// Field widths
	localparam int LEVEL_W    = 7;
	localparam int TIME_W     = 32;
	localparam int INTERVAL_W = 16;
	localparam int HYST_W     = 7;
	localparam int APB_DW     = 32;
	localparam int APB_AW     = 3;

	// Quotient of one burst average fits in the level width
	localparam int QUOT_W = LEVEL_W;
	localparam int QBIT_W = $clog2(QUOT_W);

	// Defaults and limits
	localparam int                 BURST_SAMPLES_DEF = 6;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX         = 7'd100;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RST   = 16'd1500;
	localparam logic [HYST_W-1:0]  HYST_RST          = 7'd2;

	// Register index, taken from the word address
	typedef enum logic {
		REG_INTERVAL = 1'b0,
		REG_HYST     = 1'b1
	} bls_reg_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FILT
	} bls_state_t;

endpackage

/* rtl/core/battery_level_smoother_top.sv */
// Battery level smoother: burst averaging, shared divide step and display level filter.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one battery sample item per handshake:
//   sample_ok, sample_level (saturated to 100) and now_ms. Items come in bursts of
//   BURST_SAMPLES. Only the last item of a burst yields a result item on the output
//   channel (out_valid/out_ready): level_ok and shown_level.
//   The APB port holds the minimum update interval at byte address 0 and the
//   hysteresis step at 4.
// Timing:
//   A non-final item is accumulated in the cycle it is accepted; in_ready stays high.
//   A final item with valid samples runs a restoring divide of (sum + count/2) by
//   count through one subtractor, one quotient bit per cycle, then the filter
//   step that loads the output register and raises out_valid; a burst with no
//   valid sample skips the divide. in_ready is low during that work.
// Stall and reset:
//   The result waits in an output register; the filter cycle holds until that
//   register is free. Reset clears the burst, the filter state and the registers
//   to their defaults (interval 1500 ms, hysteresis 2).
module battery_level_smoother_top
	import bls_pkg::*;
#(
	parameter int BURST_SAMPLES = BURST_SAMPLES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready,
	// sample items
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                sample_ok,
	input  logic [LEVEL_W-1:0]  sample_level,
	input  logic [TIME_W-1:0]   now_ms,
	// result items
	output logic                out_valid,
	input  logic                out_ready,
	output logic                level_ok,
	output logic [LEVEL_W-1:0]  shown_level
);

	localparam int CNT_W  = $clog2(BURST_SAMPLES + 1);
	localparam int POS_W  = $clog2(BURST_SAMPLES + 1);
	localparam int SUM_W  = $clog2(100 * BURST_SAMPLES + BURST_SAMPLES / 2 + 1);
	localparam int DW     = SUM_W + QUOT_W;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(BURST_SAMPLES - 1);

	bls_state_t state_q, state_nx;

	logic [INTERVAL_W-1:0] interval_q;
	logic [HYST_W-1:0]     hyst_q;

	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  tally_q;
	logic [POS_W-1:0]  pos_q;

	logic [SUM_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic [QUOT_W-1:0] quot_q;
	logic [QBIT_W-1:0] bit_q;
	logic [TIME_W-1:0] now_q;

	logic                primed_q;
	logic [TIME_W-1:0]   last_q;
	logic [LEVEL_W-1:0]  stable_q;

	logic                ovalid_q;
	logic                olevel_ok_q;
	logic [LEVEL_W-1:0]  oshown_q;

	logic                accept;
	logic                last_item;
	logic                div_done;
	logic                filt_go;
	logic [LEVEL_W-1:0]  lvl_sat;
	logic [SUM_W-1:0]    sum_nx;
	logic [CNT_W-1:0]    tally_nx;
	logic [DW-1:0]       div_shift;
	logic                step_ge;
	logic [TIME_W-1:0]   elapsed;
	logic                interval_ok;
	logic [LEVEL_W-1:0]  diff;
	logic [LEVEL_W:0]    mid_sum;
	logic [LEVEL_W-1:0]  stable_nx;
	logic                cfg_wr;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		prdata = '0;
		unique case (bls_reg_t'(paddr[2]))
			REG_INTERVAL: prdata = APB_DW'(interval_q);
			REG_HYST:     prdata = APB_DW'(hyst_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RST;
			hyst_q     <= HYST_RST;
		end else if (cfg_wr) begin
			unique case (bls_reg_t'(paddr[2]))
				REG_INTERVAL: interval_q <= pwdata[INTERVAL_W-1:0];
				REG_HYST:     hyst_q     <= pwdata[HYST_W-1:0];
			endcase
		end
	end

	// Burst accumulation
	assign lvl_sat   = (sample_level > LEVEL_MAX) ? LEVEL_MAX : sample_level;
	assign sum_nx    = sum_q + (sample_ok ? SUM_W'(lvl_sat) : '0);
	assign tally_nx  = tally_q + CNT_W'(sample_ok);
	assign last_item = (pos_q == POS_LAST);
	assign accept    = in_valid & in_ready;

	// Shared subtractor: one restoring divide step
	assign div_shift = DW'(div_q) << bit_q;
	assign step_ge   = (DW'(rem_q) >= div_shift);
	assign div_done  = (bit_q == '0);

	// Filter compare logic
	assign elapsed     = now_q - last_q;
	assign interval_ok = (elapsed >= TIME_W'(interval_q));
	assign diff        = (quot_q >= stable_q) ? (quot_q - stable_q) : (stable_q - quot_q);
	assign mid_sum     = {1'b0, stable_q} + {1'b0, quot_q};
	assign stable_nx   = (diff >= hyst_q) ? quot_q : mid_sum[LEVEL_W:1];

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and handshake outputs
	always_comb begin
		state_nx = state_q;
		in_ready = 1'b0;
		filt_go  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && last_item) begin
					state_nx = (tally_nx == '0) ? ST_FILT : ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_nx = ST_FILT;
				end
			end
			ST_FILT: begin
				filt_go = !ovalid_q || out_ready;
				if (filt_go) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Burst counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			tally_q <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			if (last_item) begin
				sum_q   <= '0;
				tally_q <= '0;
				pos_q   <= '0;
			end else begin
				sum_q   <= sum_nx;
				tally_q <= tally_nx;
				pos_q   <= pos_q + POS_W'(1);
			end
		end
	end

	// Divider operands and quotient
	always_ff @(posedge clk) begin
		if (accept && last_item) begin
			rem_q  <= sum_nx + SUM_W'(tally_nx >> 1);
			div_q  <= tally_nx;
			quot_q <= '0;
			bit_q  <= QBIT_W'(QUOT_W - 1);
			now_q  <= now_ms;
		end else if (state_q == ST_DIV) begin
			if (step_ge) begin
				rem_q <= SUM_W'(DW'(rem_q) - div_shift);
			end
			quot_q <= {quot_q[QUOT_W-2:0], step_ge};
			if (!div_done) begin
				bit_q <= bit_q - QBIT_W'(1);
			end
		end
	end

	// Filter state: seed, drop inside the interval, replace or average
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			last_q   <= '0;
			stable_q <= '0;
		end else if (filt_go && div_q != '0) begin
			if (!primed_q) begin
				primed_q <= 1'b1;
				last_q   <= now_q;
				stable_q <= quot_q;
			end else if (interval_ok) begin
				last_q   <= now_q;
				stable_q <= stable_nx;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (filt_go) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (filt_go) begin
			olevel_ok_q <= (div_q != '0);
			if (div_q == '0) begin
				oshown_q <= '0;
			end else if (!primed_q) begin
				oshown_q <= quot_q;
			end else if (interval_ok) begin
				oshown_q <= stable_nx;
			end else begin
				oshown_q <= stable_q;
			end
		end
	end

	assign out_valid   = ovalid_q;
	assign level_ok    = olevel_ok_q;
	assign shown_level = oshown_q;

`ifndef SYNTHESIS
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (DW'(rem_q) < (div_shift << 1)))
		else $error("divide remainder out of range");

	a_stable_range: assert property (@(posedge clk) disable iff (!arst_n)
		stable_q <= LEVEL_MAX)
		else $error("stable level above 100");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_LAST)
		else $error("burst position past end of burst");

	a_no_level_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !level_ok) |-> (shown_level == '0))
		else $error("level shown without valid samples");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_item) |=> !in_ready)
		else $error("ready right after last item of burst");
`endif

endmodule

/* bench/bls_checker.sv */
// Checker for the battery level smoother: predicts each burst result and compares the outputs.
`timescale 1ns / 1ps

module bls_checker
	import bls_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	input  logic [APB_DW-1:0]  prdata,
	input  logic               pready,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               sample_ok,
	input  logic [LEVEL_W-1:0] sample_level,
	input  logic [TIME_W-1:0]  now_ms,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               level_ok,
	input  logic [LEVEL_W-1:0] shown_level,
	output int                 fail_count,
	output int                 pending
);

	localparam int BURST_LEN = BURST_SAMPLES_DEF;

	typedef struct packed {
		logic               ok;
		logic [LEVEL_W-1:0] level;
	} level_report_t;

	// Reports still owed by the block, oldest first
	level_report_t expected_reports[$];

	// Register copies
	logic [INTERVAL_W-1:0] gap_cfg;
	logic [HYST_W-1:0]     hyst_pct;

	// Burst accumulator and display filter
	logic [9:0]         burst_total;
	int                 burst_valid;
	int                 burst_slot;
	logic               primed;
	logic [TIME_W-1:0]  last_update_ms;
	logic [LEVEL_W-1:0] stable_pct;

	// Fold one burst average into the displayed level
	function automatic logic [LEVEL_W-1:0] filter_average(input int avg,
		input logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] elapsed;
		int                change;
		if (!primed) begin
			primed         = 1'b1;
			last_update_ms = t;
			stable_pct     = avg[LEVEL_W-1:0];
			return stable_pct;
		end
		// wraps naturally at 32 bits
		elapsed = t - last_update_ms;
		if (elapsed < TIME_W'(gap_cfg))
			return stable_pct;
		last_update_ms = t;
		change = (avg >= int'(stable_pct)) ? avg - int'(stable_pct) : int'(stable_pct) - avg;
		if (change >= int'(hyst_pct))
			stable_pct = avg[LEVEL_W-1:0];
		else
			stable_pct = LEVEL_W'((int'(stable_pct) + avg) >> 1);
		return stable_pct;
	endfunction

	// Accumulate one sample; at the burst end queue the report it owes
	function automatic void absorb_sample(input logic ok, input logic [LEVEL_W-1:0] lvl,
		input logic [TIME_W-1:0] t);
		logic [LEVEL_W-1:0] capped;
		int                 avg;
		level_report_t      rep;
		capped = (lvl > LEVEL_MAX) ? LEVEL_MAX : lvl;
		if (ok) begin
			burst_total = burst_total + 10'(capped);
			burst_valid++;
		end
		burst_slot++;
		if (burst_slot < BURST_LEN)
			return;
		if (burst_valid == 0) begin
			rep.ok    = 1'b0;
			rep.level = '0;
		end else begin
			avg       = (int'(burst_total) + burst_valid / 2) / burst_valid;
			rep.ok    = 1'b1;
			rep.level = filter_average(avg, t);
		end
		burst_total = '0;
		burst_valid = 0;
		burst_slot  = 0;
		expected_reports.push_back(rep);
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		int                errs;
		level_report_t     want;
		logic [APB_DW-1:0] want_rd;
		if (!arst_n) begin
			gap_cfg        = INTERVAL_RST;
			hyst_pct       = HYST_RST;
			burst_total    = '0;
			burst_valid    = 0;
			burst_slot     = 0;
			primed         = 1'b0;
			last_update_ms = '0;
			stable_pct     = '0;
			expected_reports.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			errs = 0;

			// Track register writes, check register reads
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (bls_reg_t'(paddr[APB_AW-1:2]))
						REG_INTERVAL: gap_cfg  = pwdata[INTERVAL_W-1:0];
						REG_HYST:     hyst_pct = pwdata[HYST_W-1:0];
					endcase
				end else begin
					case (bls_reg_t'(paddr[APB_AW-1:2]))
						REG_INTERVAL: want_rd = APB_DW'(gap_cfg);
						REG_HYST:     want_rd = APB_DW'(hyst_pct);
					endcase
					if (prdata !== want_rd) begin
						$error("prdata mismatch at address %0d: expected %0h, got %0h",
							paddr, want_rd, prdata);
						errs++;
					end
				end
			end

			// Compare each result item with the oldest expectation
			if (out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					$error("unexpected result item: level_ok %0d, shown_level %0d",
						level_ok, shown_level);
					errs++;
				end else begin
					want = expected_reports.pop_front();
					if (level_ok !== want.ok) begin
						$error("level_ok mismatch: expected %0d, got %0d", want.ok, level_ok);
						errs++;
					end
					if (shown_level !== want.level) begin
						$error("shown_level mismatch: expected %0d, got %0d",
							want.level, shown_level);
						errs++;
					end
				end
			end

			// Predict from each accepted sample item
			if (in_valid && in_ready)
				absorb_sample(sample_ok, sample_level, now_ms);

			pending    <= expected_reports.size();
			fail_count <= fail_count + errs;
		end
	end

endmodule

/* bench/tb_battery_level_smoother_top.sv */
// Testbench top for the battery level smoother: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_battery_level_smoother_top;
	import bls_pkg::*;

	localparam int BURST_LEN      = BURST_SAMPLES_DEF;
	localparam int PHASE_ITEMS    = 34 * BURST_LEN;
	localparam int NUM_PHASES     = 9;
	localparam int SETTLE_CYCLES  = 12;
	localparam int WATCHDOG_LIMIT = 2000;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [APB_AW-1:0]  paddr;
	logic [APB_DW-1:0]  pwdata;
	logic [APB_DW-1:0]  prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic               sample_ok;
	logic [LEVEL_W-1:0] sample_level;
	logic [TIME_W-1:0]  now_ms;
	logic               out_valid;
	logic               out_ready;
	logic               level_ok;
	logic [LEVEL_W-1:0] shown_level;
	int                 fail_count;
	int                 pending;

	bit tx_fast;
	bit rx_fast;
	int idle_cycles;

	battery_level_smoother_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_ok    (sample_ok),
		.sample_level (sample_level),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.level_ok     (level_ok),
		.shown_level  (shown_level)
	);

	bls_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Offer one sample item after a random gap and hold it until taken
	task automatic send_sample(input logic ok, input logic [LEVEL_W-1:0] lvl,
		input logic [TIME_W-1:0] t);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		sample_ok    <= ok;
		sample_level <= lvl;
		now_ms       <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Hold off the sender until every owed result item has come out
	task automatic settle_outputs();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register access: setup cycle, access cycle, then psel and penable drop
	task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
		input logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Receiver: stall a random number of cycles before each result item
	initial begin : receiver
		int stall;
		out_ready = 1'b0;
		rx_fast   = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rx_fast ? 0 : $urandom_range(0, 6);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if ($urandom_range(0, 39) == 0)
				rx_fast = !rx_fast;
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (in_valid && in_ready) || (out_valid && out_ready) ||
			(psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("** battery_level_smoother_top: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int                 phase;
		int                 n;
		int                 iv;
		int                 hv;
		int                 base;
		int                 lvl_i;
		int                 r;
		bit                 dead_burst;
		logic               ok;
		logic [TIME_W-1:0]  clock_ms;
		logic [APB_DW-1:0]  word;

		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		in_valid     = 1'b0;
		sample_ok    = 1'b0;
		sample_level = '0;
		now_ms       = '0;
		tx_fast      = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// First burst seeds the level; levels above 100 saturate
		send_sample(1'b1, 7'd100, 32'd0);
		send_sample(1'b1, 7'd127, 32'd0);
		send_sample(1'b1, 7'd101, 32'd0);
		send_sample(1'b1, 7'd0, 32'd0);
		send_sample(1'b1, 7'd0, 32'd0);
		send_sample(1'b1, 7'd0, 32'd0);
		// Burst with no valid sample: no level, filter untouched
		send_sample(1'b0, 7'd127, 32'd10);
		send_sample(1'b0, 7'd100, 32'd11);
		send_sample(1'b0, 7'd0, 32'd12);
		send_sample(1'b0, 7'd55, 32'd13);
		send_sample(1'b0, 7'd101, 32'd14);
		send_sample(1'b0, 7'd1, 32'd15);
		// Interval not yet passed: average dropped
		send_sample(1'b1, 7'd90, 32'd100);
		send_sample(1'b1, 7'd91, 32'd101);
		send_sample(1'b0, 7'd0, 32'd102);
		send_sample(1'b0, 7'd127, 32'd103);
		send_sample(1'b0, 7'd64, 32'd104);
		send_sample(1'b0, 7'd63, 32'd105);
		// Far-off time near the top of the range: large jump replaces the level
		send_sample(1'b1, 7'd100, 32'hFFFF_FFF0);
		send_sample(1'b1, 7'd100, 32'hFFFF_FFF4);
		send_sample(1'b1, 7'd99, 32'hFFFF_FFF8);
		send_sample(1'b1, 7'd100, 32'hFFFF_FFFC);
		send_sample(1'b1, 7'd100, 32'hFFFF_FFFE);
		send_sample(1'b1, 7'd100, 32'hFFFF_FFFF);

		clock_ms = 32'hFFFF_FFFF;
		base     = 60;
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: begin iv = 0;     hv = 0;   end
				1: begin iv = 65535; hv = 100; end
				2: begin iv = 1500;  hv = 127; end
				3: begin iv = $urandom_range(0, 65535); hv = 1; end
				4: begin iv = 1;     hv = $urandom_range(0, 127); end
				5: begin iv = 300;   hv = 5;   end
				6: begin iv = $urandom_range(0, 4000); hv = 0; end
				7: begin iv = 65535; hv = 3;   end
				default: begin
					iv = $urandom_range(0, 65535);
					hv = $urandom_range(0, 127);
				end
			endcase

			// Reprogram only while the block is idle; junk in the unused upper bits
			settle_outputs();
			word = $urandom;
			word[INTERVAL_W-1:0] = iv[INTERVAL_W-1:0];
			apb_access(1'b1, {REG_INTERVAL, 2'b00}, word);
			word = $urandom;
			word[HYST_W-1:0] = hv[HYST_W-1:0];
			apb_access(1'b1, {REG_HYST, 2'b00}, word);
			apb_access(1'b0, {REG_INTERVAL, 2'b00}, '0);
			apb_access(1'b0, {REG_HYST, 2'b00}, '0);

			dead_burst = 1'b0;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// Pause mid-phase until the output side has caught up
				if (n == PHASE_ITEMS / 2)
					settle_outputs();
				if (n % 40 == 0)
					tx_fast = ($urandom_range(0, 3) == 0);
				if (n % BURST_LEN == 0)
					dead_burst = ($urandom_range(0, 9) == 0);

				// Advance time so that updates are sometimes taken, sometimes dropped
				r = $urandom_range(0, 15);
				if (r <= 9)
					clock_ms = clock_ms + TIME_W'($urandom_range(0, iv / 4 + 2));
				else if (r == 13)
					clock_ms = clock_ms + TIME_W'($urandom_range(iv / 6, iv / 5 + 1));
				else if (r == 14)
					clock_ms = $urandom;
				else if (r == 15)
					clock_ms = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 3 * iv + 10));

				// Mostly levels near a drifting base, some wide, some over range
				if ($urandom_range(0, 19) == 0)
					base = $urandom_range(0, 100);
				r = $urandom_range(0, 9);
				if (r < 7) begin
					lvl_i = base + int'($urandom_range(0, 6)) - 3;
					if (lvl_i < 0)
						lvl_i = 0;
					if (lvl_i > 100)
						lvl_i = 100;
				end else if (r < 9) begin
					lvl_i = $urandom_range(0, 100);
				end else begin
					lvl_i = $urandom_range(101, 127);
				end

				ok = dead_burst ? 1'b0 : ($urandom_range(0, 7) != 0);
				send_sample(ok, lvl_i[LEVEL_W-1:0], clock_ms);
			end
		end

		// Drain and give the verdict
		settle_outputs();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("** battery_level_smoother_top: PASSED **");
		else
			$display("** battery_level_smoother_top: FAILED **");
		$finish;
	end

endmodule
